/* sv/ahcc_pkg.sv */
`default_nettype none
package ahcc_pkg;

    localparam int ENTRIES = 512;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int TAG_W = 31;
    localparam int CNT_W = 16;
    localparam int SLOT_W = 9;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_AGE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COUNT = 2'd1;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INVALIDATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILLED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALIDATED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic valid;
        logic signed [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic pass2;
        logic kind;
        logic [TAG_W-1:0] key;
        logic found;
        logic [IDX_W-1:0] match_idx;
        logic vic_found;
        logic [IDX_W-1:0] victim;
        logic [IDX_W-1:0] idx;
        logic signed [CNT_W-1:0] threshold;
        logic signed [CNT_W-1:0] fill;
    } head_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PASS1 = 4'b0010,
        S_PASS2 = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage
`default_nettype wire

/* sv/ahcc_cell.sv */
`default_nettype none
module ahcc_cell
    import ahcc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic shift,
    input wire entry_t din,
    output entry_t dout
);

    logic [TAG_W-1:0] tag_reg;
    logic valid_reg;
    logic signed [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
            count_reg <= din.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tag_reg <= din.tag;
        end
    end

    assign dout.tag = tag_reg;
    assign dout.valid = valid_reg;
    assign dout.count = count_reg;

endmodule
`default_nettype wire

/* sv/ahcc_head.sv */
`default_nettype none
module ahcc_head
    import ahcc_pkg::*;
(
    input wire entry_t din,
    input wire head_ctrl_t ctrl,
    output entry_t dout,
    output logic hit,
    output logic vic
);

    logic signed [CNT_W-1:0] aged;

    always_comb
    begin
        aged = (din.count != CNT_MIN) ? din.count - CNT_W'(1) : din.count;
        dout = din;
        hit = 1'b0;
        vic = 1'b0;
        if (!ctrl.pass2)
        begin
            if (!ctrl.found)
            begin
                vic = !ctrl.vic_found && (din.count < ctrl.threshold);
                hit = din.valid && (din.tag == ctrl.key);
                if (hit)
                begin
                    if (ctrl.kind == KIND_INVALIDATE)
                    begin
                        dout.count = '0;
                    end
                    else if (din.count != CNT_MAX)
                    begin
                        dout.count = din.count + CNT_W'(1);
                    end
                end
                else
                begin
                    dout.count = aged;
                end
            end
        end
        else if (ctrl.kind == KIND_LOOKUP)
        begin
            if (ctrl.idx == ctrl.victim)
            begin
                dout.tag = ctrl.key;
                dout.valid = 1'b1;
                dout.count = ctrl.fill;
            end
        end
        else
        begin
            if (ctrl.idx < ctrl.match_idx)
            begin
                dout.count = aged;
            end
            else if (ctrl.idx == ctrl.match_idx && ctrl.threshold > 0)
            begin
                dout.valid = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/aging_hit_count_cache_tags.sv */
`default_nettype none
// Aging tag store with a signed hit count per entry.
// An item enters on the s_axis channel: tdata carries the key, tuser the kind
// (lookup or invalidate). Exactly one result item leaves on m_axis with the
// status and the entry index. Configuration writes arrive on the cfg channel,
// which is always ready; the writes must be made only while the block is
// idle, which the block itself does not enforce. The entries sit in a ring
// of cells that rotates by one place a cycle during a pass, so every entry
// passes the single head unit once per pass. A lookup hit, a miss with no
// free slot and an invalidate miss need one pass; a filling miss and an
// invalidate hit need a second pass. The next item can be accepted once the
// result has been moved into the output register.
// One item is in work at a time.
// The result waits in an output register; the block finishes its current
// item while the receiver stalls and holds it until the register is free.
// Reset clears every valid bit and count and sets the registers to their
// defaults; the block is ready in the first cycle after reset.
module aging_hit_count_cache_tags
    import ahcc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input wire logic [31:0] s_axis_tdata, // key [30:0], zero [31]
    input wire logic s_axis_tuser, // kind
    output logic m_axis_tvalid,
    input wire logic m_axis_tready,
    output logic [15:0] m_axis_tdata, // status [2:0], slot [11:3], zero [15:12]
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [15:0] cfg_data
);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg;
    logic kind_reg;
    logic [TAG_W-1:0] key_reg;
    logic found_reg;
    logic [IDX_W-1:0] match_reg;
    logic vic_found_reg;
    logic [IDX_W-1:0] victim_reg;
    logic signed [CNT_W-1:0] thr_reg;
    logic signed [CNT_W-1:0] fill_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    entry_t cell_q [ENTRIES];
    entry_t head_out;
    head_ctrl_t ctrl;
    logic hit;
    logic vic;
    logic shift;
    logic last;
    logic found_n;
    logic vic_n;
    logic [IDX_W-1:0] match_n;
    logic [IDX_W-1:0] victim_n;
    logic in_acc;

    assign shift = (state_reg == S_PASS1) || (state_reg == S_PASS2);
    assign last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_ring
            if (gi == ENTRIES - 1)
            begin : g_tail
                ahcc_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .din(head_out), .dout(cell_q[gi])
                );
            end
            else
            begin : g_mid
                ahcc_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .din(cell_q[gi+1]), .dout(cell_q[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ctrl.pass2 = (state_reg == S_PASS2);
        ctrl.kind = kind_reg;
        ctrl.key = key_reg;
        ctrl.found = found_reg;
        ctrl.match_idx = match_reg;
        ctrl.vic_found = vic_found_reg;
        ctrl.victim = victim_reg;
        ctrl.idx = idx_reg;
        ctrl.threshold = thr_reg;
        ctrl.fill = fill_reg;
    end

    ahcc_head u_head (
        .din(cell_q[0]),
        .ctrl(ctrl),
        .dout(head_out),
        .hit(hit),
        .vic(vic)
    );

    assign found_n = found_reg || hit;
    assign vic_n = vic_found_reg || vic;
    assign match_n = hit ? idx_reg : match_reg;
    assign victim_n = vic ? idx_reg : victim_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_PASS1;
                end
            end
            S_PASS1:
            begin
                if (last)
                begin
                    if (kind_reg == KIND_LOOKUP ? (!found_n && vic_n) : found_n)
                    begin
                        state_next = S_PASS2;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PASS2:
            begin
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
            thr_reg <= 16'sd10;
            fill_reg <= 16'sd30;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == REG_AGE_THRESHOLD)
            begin
                thr_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_FILL_COUNT)
            begin
                fill_reg <= cfg_data;
            end
            if (in_acc)
            begin
                found_reg <= 1'b0;
                vic_found_reg <= 1'b0;
                idx_reg <= '0;
            end
            else if (shift)
            begin
                idx_reg <= last ? '0 : idx_reg + IDX_W'(1);
                if (state_reg == S_PASS1)
                begin
                    found_reg <= found_n;
                    vic_found_reg <= vic_n;
                end
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= s_axis_tuser;
            key_reg <= s_axis_tdata[TAG_W-1:0];
        end
        if (state_reg == S_PASS1)
        begin
            match_reg <= match_n;
            victim_reg <= victim_n;
            if (last)
            begin
                if (kind_reg == KIND_LOOKUP)
                begin
                    if (found_n)
                    begin
                        res_status_reg <= ST_HIT;
                        res_slot_reg <= SLOT_W'(match_n);
                    end
                    else if (vic_n)
                    begin
                        res_status_reg <= ST_FILLED;
                        res_slot_reg <= SLOT_W'(victim_n);
                    end
                    else
                    begin
                        res_status_reg <= ST_NO_SLOT;
                        res_slot_reg <= '0;
                    end
                end
                else if (found_n)
                begin
                    res_status_reg <= ST_INVALIDATED;
                    res_slot_reg <= SLOT_W'(match_n);
                end
                else
                begin
                    res_status_reg <= ST_NOT_PRESENT;
                    res_slot_reg <= '0;
                end
            end
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg <= res_slot_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'b0000, out_slot_reg, out_status_reg};

    a_pass2_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS2) |-> (kind_reg == KIND_LOOKUP ? vic_found_reg : found_reg))
        else $error("second pass without a victim or a match");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_PASS1 && idx_reg == '0))
        else $error("accepted item did not start a scan at entry zero");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> (idx_reg == '0))
        else $error("scan index not at zero outside a scan");

endmodule
`default_nettype wire
